@@ design/lzs_pkg.sv @@
// Shared types and constants for the longest zero-sum subarray block.
// No dependencies; lzs_front, lzs_back and the top level import this package.
`default_nettype none

package lzs_pkg;

	localparam int unsigned ELEM_W = 16;

	typedef struct packed {
		logic signed [ELEM_W-1:0] value;
		logic                     last_in;
	} in_item_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] element;
		logic                     last_out;
		logic                     empty_res;
		logic                     overflow;
	} result_t;

	typedef struct packed {
		in_item_t item;
		logic     drop;
	} fr_item_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FETCH,
		BK_EMIT
	} bk_state_t;

endpackage

`default_nettype wire

@@ design/lzs_queue.sv @@
// Small first-in first-out queue between the front and back sections.
// Depends on nothing but its width and depth parameters.
`default_nettype none

module lzs_queue #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic                  valid,
	output logic      [WIDTH-1:0] rd_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == NW'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign rd_data = slot_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

@@ design/lzs_front.sv @@
// Front section: accepts input words, numbers them within the sequence
// and marks those beyond capacity for dropping. Uses lzs_pkg.
`default_nettype none

module lzs_front
	import lzs_pkg::*;
#(
	parameter int unsigned MAX_ELEMENTS = 64,
	parameter int unsigned IW           = 6,
	parameter int unsigned CW           = 7
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire in_item_t       item,
	input  wire logic           q_full,
	output logic                q_push,
	output fr_item_t            q_item,
	output logic      [IW-1:0]  q_idx
);

	logic [CW-1:0] cnt_q;
	logic          drop;

	assign drop          = (cnt_q == CW'(MAX_ELEMENTS));
	assign q_push        = push && !q_full;
	assign q_item.item   = item;
	assign q_item.drop   = drop;
	assign q_idx         = cnt_q[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (q_push) begin
			if (item.last_in) begin
				cnt_q <= '0;
			end else if (!drop) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ design/lzs_back.sv @@
// Back section: stores elements, tracks prefix sums, searches the table of
// first occurrences and streams out the best span. Uses lzs_pkg.
`default_nettype none

module lzs_back
	import lzs_pkg::*;
#(
	parameter int unsigned MAX_ELEMENTS = 64,
	parameter int unsigned IW           = 6,
	parameter int unsigned CW           = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire fr_item_t      q_item,
	input  wire logic [IW-1:0] q_idx,
	output logic               q_pop,
	output logic               empty,
	input  wire logic          pop,
	output result_t            result
);

	localparam int unsigned SW = ELEM_W + CW;

	bk_state_t             state_q;
	bk_state_t             state_d;

	logic signed [SW-1:0]  sum_q;
	logic signed [SW-1:0]  sum_new;
	logic [CW-1:0]         seen_cnt_q;
	logic [IW-1:0]         best_start_q;
	logic [CW-1:0]         best_len_q;
	logic                  dropped_q;
	logic [IW-1:0]         cmp_k_q;
	logic [IW-1:0]         emit_k_q;
	logic [IW-1:0]         idx_q;
	logic                  last_q;

	logic [ELEM_W-1:0]     elem_mem [MAX_ELEMENTS];
	logic [ELEM_W-1:0]     elem_rd_q;
	logic [IW-1:0]         elem_ra;

	logic [SW+IW-1:0]      seen_mem [MAX_ELEMENTS];
	logic [SW+IW-1:0]      seen_rd_q;
	logic [IW-1:0]         seen_ra;
	logic [IW-1:0]         seen_wa;
	logic [SW+IW-1:0]      seen_wd;
	logic                  seen_we;

	logic [SW-1:0]         rd_sum;
	logic [IW-1:0]         rd_first;
	logic [IW-1:0]         span_len;
	logic                  match;
	logic                  scan_last;
	logic                  take;
	logic                  store;
	logic                  emit_final;
	logic                  out_free;
	logic                  out_load;
	logic                  out_valid_q;
	result_t               out_q;

	assign sum_new    = sum_q + SW'(q_item.item.value);
	assign rd_sum     = seen_rd_q[SW+IW-1:IW];
	assign rd_first   = seen_rd_q[IW-1:0];
	assign span_len   = idx_q - rd_first;
	assign match      = (rd_sum == sum_q);
	assign scan_last  = ((CW'(cmp_k_q) + CW'(1)) == seen_cnt_q);
	assign take       = (state_q == BK_IDLE) && q_valid;
	assign store      = take && !q_item.drop;
	assign emit_final = (best_len_q == '0) || ((CW'(emit_k_q) + CW'(1)) == best_len_q);
	assign out_free   = !out_valid_q || pop;
	assign elem_ra    = best_start_q + emit_k_q;
	assign empty      = !out_valid_q;
	assign result     = out_q;

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		seen_we  = 1'b0;
		seen_wa  = '0;
		seen_wd  = {sum_new, q_idx};
		seen_ra  = '0;
		out_load = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (!q_item.drop) begin
						if (sum_new != '0 && seen_cnt_q == '0) begin
							seen_we = 1'b1;
						end
					end
					if (!q_item.drop && sum_new != '0 && seen_cnt_q != '0) begin
						state_d = BK_SCAN;
					end else if (q_item.item.last_in) begin
						state_d = BK_FETCH;
					end
				end
			end
			BK_SCAN: begin
				seen_ra = cmp_k_q + IW'(1);
				if (!match && scan_last) begin
					seen_we = 1'b1;
					seen_wa = seen_cnt_q[IW-1:0];
					seen_wd = {sum_q, idx_q};
				end
				if (match || scan_last) begin
					state_d = last_q ? BK_FETCH : BK_IDLE;
				end
			end
			BK_FETCH: begin
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = emit_final ? BK_IDLE : BK_FETCH;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			sum_q        <= '0;
			seen_cnt_q   <= '0;
			best_start_q <= '0;
			best_len_q   <= '0;
			dropped_q    <= 1'b0;
			cmp_k_q      <= '0;
			emit_k_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (seen_we) begin
				seen_cnt_q <= seen_cnt_q + CW'(1);
			end
			if (take) begin
				cmp_k_q <= '0;
				if (q_item.drop) begin
					dropped_q <= 1'b1;
				end else begin
					sum_q <= sum_new;
					if (sum_new == '0 && (CW'(q_idx) + CW'(1)) > best_len_q) begin
						best_start_q <= '0;
						best_len_q   <= CW'(q_idx) + CW'(1);
					end
				end
			end
			if (state_q == BK_SCAN) begin
				if (match) begin
					if (CW'(span_len) > best_len_q) begin
						best_start_q <= rd_first + IW'(1);
						best_len_q   <= CW'(span_len);
					end
				end else if (!scan_last) begin
					cmp_k_q <= cmp_k_q + IW'(1);
				end
			end
			if (out_load) begin
				if (emit_final) begin
					emit_k_q     <= '0;
					sum_q        <= '0;
					seen_cnt_q   <= '0;
					best_start_q <= '0;
					best_len_q   <= '0;
					dropped_q    <= 1'b0;
				end else begin
					emit_k_q <= emit_k_q + IW'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			idx_q  <= q_idx;
			last_q <= q_item.item.last_in;
		end
		if (out_load) begin
			out_q.element   <= (best_len_q == '0) ? '0 : elem_rd_q;
			out_q.last_out  <= emit_final;
			out_q.empty_res <= (best_len_q == '0);
			out_q.overflow  <= dropped_q;
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			elem_mem[q_idx] <= q_item.item.value;
		end
		elem_rd_q <= elem_mem[elem_ra];
	end

	always_ff @(posedge clk) begin
		if (seen_we) begin
			seen_mem[seen_wa] <= seen_wd;
		end
		seen_rd_q <= seen_mem[seen_ra];
	end

endmodule

`default_nettype wire

@@ design/longest_zero_sum_subarray.sv @@
// Longest zero-sum subarray finder, top level.
// Instantiates lzs_front, lzs_queue and lzs_back; uses lzs_pkg.
//
// Input channel: push/full with one signed element and a last flag per word.
// Result channel: empty/pop; result holds the oldest waiting word while empty
// is low. Each sequence ends with its last-flagged element; then the block
// emits the longest zero-sum span (earliest one on a tie), one element per
// word with last_out on the final word, or a single word with empty_res set
// when no such span exists. overflow reports elements dropped past
// MAX_ELEMENTS and is the same on every word of a run.
// Per element, the new nonzero prefix sum is compared with the distinct
// nonzero prefix sums in the first-occurrence table (one read port, searched
// in order and stopping at the first hit). A two-word queue lets input keep
// arriving while the search runs.
// Emission: each result word takes an element memory read, then a load of
// the output register. When pop is held low, the output register holds its
// word, emission waits, and input backs up into the queue until full rises.
// Reset clears all control state at once; no clearing pass is needed since
// stored entries are read only after they are written.
`default_nettype none

module longest_zero_sum_subarray
	import lzs_pkg::*;
#(
	parameter int unsigned MAX_ELEMENTS = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t item,
	output logic          empty,
	input  wire logic     pop,
	output result_t       result
);

	localparam int unsigned IW = $clog2(MAX_ELEMENTS);
	localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
	localparam int unsigned QW = IW + $bits(fr_item_t);

	logic          q_push;
	logic          q_pop;
	logic          q_valid;
	fr_item_t      fr_item;
	logic [IW-1:0] fr_idx;
	fr_item_t      bk_item;
	logic [IW-1:0] bk_idx;
	logic [QW-1:0] q_rd_data;

	lzs_front #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.IW          (IW),
		.CW          (CW)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.item  (item),
		.q_full(full),
		.q_push(q_push),
		.q_item(fr_item),
		.q_idx (fr_idx)
	);

	lzs_queue #(
		.WIDTH(QW),
		.DEPTH(2)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data({fr_idx, fr_item}),
		.full   (full),
		.rd_en  (q_pop),
		.valid  (q_valid),
		.rd_data(q_rd_data)
	);

	assign bk_idx  = q_rd_data[QW-1:$bits(fr_item_t)];
	assign bk_item = q_rd_data[$bits(fr_item_t)-1:0];

	lzs_back #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.IW          (IW),
		.CW          (CW)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_item (bk_item),
		.q_idx  (bk_idx),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

`ifndef ASSERT_OFF
	a_empty_res_alone : assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.empty_res |-> result.last_out && result.element == '0)
		else $error("empty result word is not a lone final word");

	a_ovf_steady : assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !result.last_out ##1 !empty |-> result.overflow == $past(result.overflow))
		else $error("overflow changed within a run");

	a_empty_not_mid : assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !result.last_out ##1 !empty |-> !result.empty_res)
		else $error("empty result word inside a run");
`endif

endmodule

`default_nettype wire
